// ===== sv/dsbm_pkg.sv =====
// Shared types and constants for the drive speed bias mapper.
// Used by every module of the block except the generic dsbm_div; depends on nothing.
`default_nettype none
package dsbm_pkg;

  localparam int SPEED_W = 16;
  localparam int MAG_W   = 15;
  localparam int BIAS_W  = 16;
  localparam int NUM_W   = 32;
  localparam int BQ_W    = 17;
  localparam int LDVD_W  = 30;
  localparam int PROD_W  = 31;
  localparam int FRAC_W  = 14;

  localparam logic [BIAS_W-1:0] BIAS_ONE  = 16'd16384;
  localparam logic [PROD_W-1:0] ROUND_RHT = 31'd8192;

  localparam logic [MAG_W-1:0]  MAX_SPEED_RST = 15'd32512;
  localparam logic [MAG_W-1:0]  MID_SPEED_RST = 15'd16384;
  localparam logic [BIAS_W-1:0] BIAS_RST      = 16'd16384;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED      = 3'd0,
    CFG_MID_SPEED      = 3'd1,
    CFG_BIAS_LOW_FWD   = 3'd2,
    CFG_BIAS_HIGH_FWD  = 3'd3,
    CFG_BIAS_LOW_BACK  = 3'd4,
    CFG_BIAS_HIGH_BACK = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [MAG_W-1:0]  max_speed;
    logic [MAG_W-1:0]  mid_speed;
    logic [BIAS_W-1:0] bias_low_fwd;
    logic [BIAS_W-1:0] bias_high_fwd;
    logic [BIAS_W-1:0] bias_low_back;
    logic [BIAS_W-1:0] bias_high_back;
  } cfg_t;

  // Side data that travels alongside the blend division.
  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic              blend;
    logic [BIAS_W-1:0] fix_bias;
  } band_side_t;

  // Side data that travels alongside the left-side division.
  typedef struct packed {
    logic              neg;
    logic [BIAS_W-1:0] bias;
    logic              big;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] rprod;
  } mix_side_t;

endpackage
`default_nettype wire

// ===== sv/dsbm_band.sv =====
// Front stages: clamp, band selection and the blend numerator.
// Depends on dsbm_pkg.
`default_nettype none
module dsbm_band (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire dsbm_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  input  wire logic signed [dsbm_pkg::SPEED_W-1:0] speed_command,
  output logic                               out_valid,
  output logic [dsbm_pkg::NUM_W-1:0]         num,
  output logic [dsbm_pkg::MAG_W-1:0]         den,
  output dsbm_pkg::band_side_t               side
);

  logic [dsbm_pkg::SPEED_W-1:0] raw;
  logic [dsbm_pkg::SPEED_W-1:0] mag_raw;
  logic                         over;
  logic                         above_mid;
  logic [dsbm_pkg::MAG_W-1:0]   mag_c;
  logic [dsbm_pkg::BIAS_W-1:0]  lo_c;
  logic [dsbm_pkg::BIAS_W-1:0]  hi_c;

  // Stage 1 registers.
  logic                         v1;
  dsbm_pkg::band_side_t         s1;
  logic [dsbm_pkg::BIAS_W-1:0]  lo1;
  logic [dsbm_pkg::BIAS_W-1:0]  hi1;
  logic [dsbm_pkg::MAG_W-1:0]   wlo1;
  logic [dsbm_pkg::MAG_W-1:0]   whi1;
  logic [dsbm_pkg::MAG_W-1:0]   den1;
  // Stage 2 registers.
  logic                         v2;
  dsbm_pkg::band_side_t         s2;
  logic [dsbm_pkg::PROD_W-1:0]  plo2;
  logic [dsbm_pkg::PROD_W-1:0]  phi2;
  logic [dsbm_pkg::MAG_W-1:0]   den2;

  always_comb begin
    raw       = speed_command;
    mag_raw   = raw[dsbm_pkg::SPEED_W-1] ? (~raw + 16'd1) : raw;
    over      = mag_raw > {1'b0, cfg.max_speed};
    above_mid = mag_raw > {1'b0, cfg.mid_speed};
    mag_c     = over ? cfg.max_speed : mag_raw[dsbm_pkg::MAG_W-1:0];
    lo_c      = raw[dsbm_pkg::SPEED_W-1] ? cfg.bias_low_back  : cfg.bias_low_fwd;
    hi_c      = raw[dsbm_pkg::SPEED_W-1] ? cfg.bias_high_back : cfg.bias_high_fwd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.neg      <= raw[dsbm_pkg::SPEED_W-1];
      s1.mag      <= mag_c;
      s1.blend    <= !over && above_mid;
      s1.fix_bias <= over ? hi_c : lo_c;
      lo1         <= lo_c;
      hi1         <= hi_c;
      wlo1        <= cfg.max_speed - mag_c;
      whi1        <= mag_c - cfg.mid_speed;
      den1        <= cfg.max_speed - cfg.mid_speed;

      s2   <= s1;
      plo2 <= lo1 * wlo1;
      phi2 <= hi1 * whi1;
      den2 <= den1;

      side <= s2;
      num  <= dsbm_pkg::NUM_W'(plo2) + dsbm_pkg::NUM_W'(phi2)
            + dsbm_pkg::NUM_W'(den2 >> 1);
      den  <= den2;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dsbm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Generic; the caller guarantees that the quotient fits in Q bits.
`default_nettype none
module dsbm_div #(
  parameter int N = 32,
  parameter int D = 15,
  parameter int Q = 17,
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  input  wire logic [W-1:0] in_side,
  output logic              out_valid,
  output logic [Q-1:0]      quotient,
  output logic [W-1:0]      out_side
);

  logic         vld [Q];
  logic [D-1:0] rem [Q];
  logic [Q-1:0] quo [Q];
  logic [Q-1:0] low [Q];
  logic [D-1:0] dsr [Q];
  logic [W-1:0] sd  [Q];

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic         v_p;
    logic [D-1:0] r_p;
    logic [Q-1:0] q_p;
    logic [Q-1:0] l_p;
    logic [D-1:0] d_p;
    logic [W-1:0] s_p;
    logic [D:0]   trial;
    logic         take;

    if (k == 0) begin : g_first
      assign v_p = in_valid;
      assign r_p = D'(dividend[N-1:Q]);
      assign q_p = '0;
      assign l_p = dividend[Q-1:0];
      assign d_p = divisor;
      assign s_p = in_side;
    end else begin : g_next
      assign v_p = vld[k-1];
      assign r_p = rem[k-1];
      assign q_p = quo[k-1];
      assign l_p = low[k-1];
      assign d_p = dsr[k-1];
      assign s_p = sd[k-1];
    end

    assign trial = {r_p, l_p[Q-1]} - {1'b0, d_p};
    assign take  = ({r_p, l_p[Q-1]} >= {1'b0, d_p});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? trial[D-1:0] : {r_p[D-2:0], l_p[Q-1]};
        quo[k] <= {q_p[Q-2:0], take};
        low[k] <= {l_p[Q-2:0], 1'b0};
        dsr[k] <= d_p;
        sd[k]  <= s_p;
      end
    end
  end

  assign out_valid = vld[Q-1];
  assign quotient  = quo[Q-1];
  assign out_side  = sd[Q-1];

endmodule
`default_nettype wire

// ===== sv/dsbm_mix.sv =====
// Bias selection after the blend division, and the operands of both drive sides.
// Depends on dsbm_pkg.
`default_nettype none
module dsbm_mix (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [dsbm_pkg::BQ_W-1:0]    blend_q,
  input  wire dsbm_pkg::band_side_t         in_side,
  output logic                              out_valid,
  output logic [dsbm_pkg::LDVD_W-1:0]       dividend,
  output dsbm_pkg::mix_side_t               out_side
);

  logic [dsbm_pkg::BIAS_W-1:0] bias;

  always_comb begin
    if (in_side.blend) begin
      bias = blend_q[dsbm_pkg::BQ_W-1] ? '1 : blend_q[dsbm_pkg::BIAS_W-1:0];
    end else begin
      bias = in_side.fix_bias;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dividend       <= {1'b0, in_side.mag, {dsbm_pkg::FRAC_W{1'b0}}}
                      + dsbm_pkg::LDVD_W'(bias[dsbm_pkg::BIAS_W-1:1]);
      out_side.neg   <= in_side.neg;
      out_side.bias  <= bias;
      out_side.big   <= bias > dsbm_pkg::BIAS_ONE;
      out_side.mag   <= in_side.mag;
      out_side.rprod <= in_side.mag * bias;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dsbm_out.sv =====
// Output register: picks each side's magnitude, applies the sign.
// Depends on dsbm_pkg.
`default_nettype none
module dsbm_out (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [dsbm_pkg::MAG_W-1:0]         left_q,
  input  wire dsbm_pkg::mix_side_t                in_side,
  output logic                                    out_valid,
  output logic signed [dsbm_pkg::SPEED_W-1:0]     left_drive,
  output logic signed [dsbm_pkg::SPEED_W-1:0]     right_drive,
  output logic [dsbm_pkg::BIAS_W-1:0]             bias_used
);

  logic [dsbm_pkg::PROD_W-1:0]  rsum;
  logic [dsbm_pkg::MAG_W-1:0]   lmag;
  logic [dsbm_pkg::MAG_W-1:0]   rmag;
  logic [dsbm_pkg::SPEED_W-1:0] lext;
  logic [dsbm_pkg::SPEED_W-1:0] rext;

  always_comb begin
    rsum = in_side.rprod + dsbm_pkg::ROUND_RHT;
    lmag = in_side.big ? left_q : in_side.mag;
    rmag = in_side.big ? in_side.mag
                       : rsum[dsbm_pkg::FRAC_W+dsbm_pkg::MAG_W-1:dsbm_pkg::FRAC_W];
    lext = {1'b0, lmag};
    rext = {1'b0, rmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_drive  <= in_side.neg ? (~lext + 16'd1) : lext;
      right_drive <= in_side.neg ? (~rext + 16'd1) : rext;
      bias_used   <= in_side.bias;
    end
  end

endmodule
`default_nettype wire

// ===== sv/drive_speed_bias_mapper.sv =====
// Top level of the drive speed bias mapper: config registers and the pipeline.
// Depends on dsbm_pkg, dsbm_band, dsbm_div, dsbm_mix and dsbm_out.
//
// The block maps one signed Q8.8 speed command to a left drive, a right drive
// and the Q2.14 left/right bias that was applied. The command is clamped to
// plus or minus max_speed, a bias is picked by direction (low up to mid speed,
// high beyond max speed, a rounded linear blend in between), and then either
// the left side is divided down by a bias above one or the right side is
// scaled by a bias of at most one. The pipeline accepts one item every cycle
// while it is not stalled: three front stages form the blend numerator, a
// 17-stage divider produces the blended bias one quotient bit a stage, one
// stage selects the bias and forms the drive operands, a 15-stage divider
// produces the left magnitude, and the last stage is the output register.
// When the output is stalled while holding an item, the whole pipeline
// holds, so speed_stall follows drive_stall in that case.
// Configuration writes are always ready and take effect at once; they should
// only be issued while no item is in flight.
`default_nettype none
module drive_speed_bias_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [2:0]                         cfg_index,
  input  wire logic [15:0]                        cfg_data,
  input  wire logic                               speed_valid,
  output logic                                    speed_stall,
  input  wire logic signed [dsbm_pkg::SPEED_W-1:0] speed_command,
  output logic                                    drive_valid,
  input  wire logic                               drive_stall,
  output logic signed [dsbm_pkg::SPEED_W-1:0]     left_drive,
  output logic signed [dsbm_pkg::SPEED_W-1:0]     right_drive,
  output logic [dsbm_pkg::BIAS_W-1:0]             bias_used
);

  dsbm_pkg::cfg_t cfg;
  logic           en;

  logic                          band_valid;
  logic [dsbm_pkg::NUM_W-1:0]    band_num;
  logic [dsbm_pkg::MAG_W-1:0]    band_den;
  dsbm_pkg::band_side_t          band_side;

  logic                          bdiv_valid;
  logic [dsbm_pkg::BQ_W-1:0]     bdiv_q;
  dsbm_pkg::band_side_t          bdiv_side;

  logic                          mix_valid;
  logic [dsbm_pkg::LDVD_W-1:0]   mix_dvd;
  dsbm_pkg::mix_side_t           mix_side;

  logic                          ldiv_valid;
  logic [dsbm_pkg::MAG_W-1:0]    ldiv_q;
  dsbm_pkg::mix_side_t           ldiv_side;

  // The whole pipeline moves together unless a finished item is held at the output.
  assign en          = !(drive_valid && drive_stall);
  assign speed_stall = !en;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed      <= dsbm_pkg::MAX_SPEED_RST;
      cfg.mid_speed      <= dsbm_pkg::MID_SPEED_RST;
      cfg.bias_low_fwd   <= dsbm_pkg::BIAS_RST;
      cfg.bias_high_fwd  <= dsbm_pkg::BIAS_RST;
      cfg.bias_low_back  <= dsbm_pkg::BIAS_RST;
      cfg.bias_high_back <= dsbm_pkg::BIAS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dsbm_pkg::CFG_MAX_SPEED:      cfg.max_speed      <= cfg_data[14:0];
        dsbm_pkg::CFG_MID_SPEED:      cfg.mid_speed      <= cfg_data[14:0];
        dsbm_pkg::CFG_BIAS_LOW_FWD:   cfg.bias_low_fwd   <= cfg_data;
        dsbm_pkg::CFG_BIAS_HIGH_FWD:  cfg.bias_high_fwd  <= cfg_data;
        dsbm_pkg::CFG_BIAS_LOW_BACK:  cfg.bias_low_back  <= cfg_data;
        dsbm_pkg::CFG_BIAS_HIGH_BACK: cfg.bias_high_back <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dsbm_band u_band (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .cfg           (cfg),
    .in_valid      (speed_valid),
    .speed_command (speed_command),
    .out_valid     (band_valid),
    .num           (band_num),
    .den           (band_den),
    .side          (band_side)
  );

  // Blended bias: (numerator + den/2) / den, up to 17 quotient bits.
  dsbm_div #(
    .N (dsbm_pkg::NUM_W),
    .D (dsbm_pkg::MAG_W),
    .Q (dsbm_pkg::BQ_W),
    .W ($bits(dsbm_pkg::band_side_t))
  ) u_blend_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (band_valid),
    .dividend  (band_num),
    .divisor   (band_den),
    .in_side   (band_side),
    .out_valid (bdiv_valid),
    .quotient  (bdiv_q),
    .out_side  (bdiv_side)
  );

  dsbm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (bdiv_valid),
    .blend_q   (bdiv_q),
    .in_side   (bdiv_side),
    .out_valid (mix_valid),
    .dividend  (mix_dvd),
    .out_side  (mix_side)
  );

  // Left magnitude for a bias above one: (mag * 16384 + bias/2) / bias.
  dsbm_div #(
    .N (dsbm_pkg::LDVD_W),
    .D (dsbm_pkg::BIAS_W),
    .Q (dsbm_pkg::MAG_W),
    .W ($bits(dsbm_pkg::mix_side_t))
  ) u_left_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mix_valid),
    .dividend  (mix_dvd),
    .divisor   (mix_side.bias),
    .in_side   (mix_side),
    .out_valid (ldiv_valid),
    .quotient  (ldiv_q),
    .out_side  (ldiv_side)
  );

  dsbm_out u_out (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (ldiv_valid),
    .left_q      (ldiv_q),
    .in_side     (ldiv_side),
    .out_valid   (drive_valid),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .bias_used   (bias_used)
  );

endmodule
`default_nettype wire

// ===== tb/tb_drive_speed_bias_mapper.sv =====
// Self-checking testbench for the drive speed bias mapper.
// Depends on dsbm_pkg and drive_speed_bias_mapper; drives directed and random
// speed commands across several register settings and checks every result.
`timescale 1ns / 100ps
`default_nettype none
module tb_drive_speed_bias_mapper;

  localparam int LATENCY   = 37;
  localparam int CYCLE_MAX = 200000;
  localparam int RAND_PER  = 90;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        speed_valid;
  logic        speed_stall;
  logic signed [15:0] speed_command;
  logic        drive_valid;
  logic        drive_stall;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic [15:0] bias_used;

  drive_speed_bias_mapper u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .speed_valid(speed_valid), .speed_stall(speed_stall),
    .speed_command(speed_command),
    .drive_valid(drive_valid), .drive_stall(drive_stall),
    .left_drive(left_drive), .right_drive(right_drive), .bias_used(bias_used)
  );

  // One drive result: the two sides and the bias that produced them.
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] bias;
  } drive_t;

  // A directed row: the command, and optionally a hand-computed result.
  typedef struct packed {
    logic [15:0] cmd;
    logic        known;
    drive_t      want;
  } row_t;

  // The testbench's own copy of the register file.
  logic [14:0] m_max, m_mid;
  logic [15:0] m_lo_f, m_hi_f, m_lo_b, m_hi_b;

  drive_t drive_q[$];
  int     errors = 0;
  int     cycles = 0;
  bit     rx_random;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Interpolate between the low and high bias for a magnitude inside the band,
  // rounding to nearest with ties upward.
  function automatic logic [15:0] blend_bias(logic [14:0] mag, logic [15:0] lo,
                                             logic [15:0] hi);
    longint span, num, q;
    span = longint'(m_max) - longint'(m_mid);
    num  = longint'(lo) * (longint'(m_max) - longint'(mag)) +
           longint'(hi) * (longint'(mag) - longint'(m_mid));
    q = (num + span / 2) / span;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] signed_of(bit neg, longint mag);
    if (neg && mag != 0) begin
      if (mag > 32768) mag = 32768;
      return 16'(-mag);
    end
    if (mag > 32767) mag = 32767;
    return mag[15:0];
  endfunction

  function automatic drive_t map_speed(logic [15:0] cmd);
    drive_t r;
    bit     neg;
    longint mag, lmag, rmag;
    logic [15:0] bias, lo, hi;
    neg = cmd[15];
    mag = neg ? (65536 - longint'(cmd)) : longint'(cmd);
    lo  = neg ? m_lo_b : m_lo_f;
    hi  = neg ? m_hi_b : m_hi_f;
    if (mag > m_max) begin
      mag  = m_max;
      bias = hi;
    end else if (mag > m_mid) begin
      bias = blend_bias(mag[14:0], lo, hi);
    end else begin
      bias = lo;
    end
    if (bias > dsbm_pkg::BIAS_ONE) begin
      lmag = (mag * 16384 + bias / 2) / bias;
      rmag = mag;
    end else begin
      lmag = mag;
      rmag = (mag * bias + 8192) >> 14;
    end
    r.left  = signed_of(neg, lmag);
    r.right = signed_of(neg, rmag);
    r.bias  = bias;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Result side: once random mode is on, stall on its own random pattern; check each accepted item.
  always @(posedge clk) begin
    drive_t e;
    if (rst) begin
      drive_stall <= 1'b0;
    end else begin
      drive_stall <= rx_random ? ($urandom_range(0, 3) == 0) : 1'b0;
      if (drive_valid && !drive_stall) begin
        if (drive_q.size() == 0) begin
          report("unexpected result, left_drive", left_drive, 16'h0000);
        end else begin
          e = drive_q.pop_front();
          if (left_drive !== e.left) report("left_drive", left_drive, e.left);
          if (right_drive !== e.right) report("right_drive", right_drive, e.right);
          if (bias_used !== e.bias) report("bias_used", bias_used, e.bias);
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("drive_speed_bias_mapper verification failed");
      $finish;
    end
  end

  task automatic write_reg(dsbm_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dsbm_pkg::CFG_MAX_SPEED:      m_max  = val[14:0];
      dsbm_pkg::CFG_MID_SPEED:      m_mid  = val[14:0];
      dsbm_pkg::CFG_BIAS_LOW_FWD:   m_lo_f = val;
      dsbm_pkg::CFG_BIAS_HIGH_FWD:  m_hi_f = val;
      dsbm_pkg::CFG_BIAS_LOW_BACK:  m_lo_b = val;
      dsbm_pkg::CFG_BIAS_HIGH_BACK: m_hi_b = val;
      default: begin
      end
    endcase
  endtask

  // Offer one command and hold it until the block takes it.
  task automatic send_speed(logic [15:0] cmd, drive_t want);
    speed_valid   <= 1'b1;
    speed_command <= cmd;
    @(posedge clk);
    while (speed_stall) @(posedge clk);
    drive_q.push_back(want);
  endtask

  task automatic send_gap();
    speed_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Let the pipeline drain before touching the registers.
  task automatic drain();
    speed_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] mx, logic [15:0] md, logic [15:0] lf,
                         logic [15:0] hf, logic [15:0] lb, logic [15:0] hb);
    write_reg(dsbm_pkg::CFG_MAX_SPEED, mx);
    write_reg(dsbm_pkg::CFG_MID_SPEED, md);
    write_reg(dsbm_pkg::CFG_BIAS_LOW_FWD, lf);
    write_reg(dsbm_pkg::CFG_BIAS_HIGH_FWD, hf);
    write_reg(dsbm_pkg::CFG_BIAS_LOW_BACK, lb);
    write_reg(dsbm_pkg::CFG_BIAS_HIGH_BACK, hb);
  endtask

  // Random commands in bursts, weighted toward the band edges.
  task automatic random_speeds(int count);
    int burst;
    logic [15:0] cmd;
    int pick;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: cmd = 16'(m_max) + 16'($urandom_range(0, 2)) - 16'd1;
          1: cmd = 16'(m_mid) + 16'($urandom_range(0, 2)) - 16'd1;
          2: cmd = -(16'(m_max) + 16'($urandom_range(0, 2)) - 16'd1);
          3: cmd = -(16'(m_mid) + 16'($urandom_range(0, 2)) - 16'd1);
          default: cmd = 16'($urandom);
        endcase
        send_speed(cmd, map_speed(cmd));
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) send_gap();
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(logic [15:0] cmd, bit known, logic [15:0] l,
                              logic [15:0] r, logic [15:0] b);
    row_t x;
    x.cmd = cmd;
    x.known = known;
    x.want.left = l;
    x.want.right = r;
    x.want.bias = b;
    return x;
  endfunction

  initial begin
    drive_t w;
    rx_random = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    speed_valid = 1'b0;
    speed_command = '0;
    m_max = dsbm_pkg::MAX_SPEED_RST;
    m_mid = dsbm_pkg::MID_SPEED_RST;
    m_lo_f = dsbm_pkg::BIAS_RST;
    m_hi_f = dsbm_pkg::BIAS_RST;
    m_lo_b = dsbm_pkg::BIAS_RST;
    m_hi_b = dsbm_pkg::BIAS_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset settings: every bias is exactly one, so
    // both sides follow the clamped command.
    rows.push_back(mk(16'h0000, 1, 16'h0000, 16'h0000, 16'h4000));
    rows.push_back(mk(16'h7FFF, 1, 16'h7F00, 16'h7F00, 16'h4000));
    rows.push_back(mk(16'h8000, 1, 16'h8100, 16'h8100, 16'h4000));
    rows.push_back(mk(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'h4000));
    rows.push_back(mk(16'h0001, 1, 16'h0001, 16'h0001, 16'h4000));
    rows.push_back(mk(16'h5555, 0, 0, 0, 0));
    rows.push_back(mk(16'hAAAA, 0, 0, 0, 0));
    foreach (rows[i]) begin
      w = rows[i].known ? rows[i].want : map_speed(rows[i].cmd);
      send_speed(rows[i].cmd, w);
    end
    drain();

    // Biases differ per band, each direction with one bias above one and one below, so
    // blends, division on the left and scaling on the right all occur.
    set_all(16'd20000, 16'd8000, 16'd12000, 16'd30000, 16'd20000, 16'd6000);
    rows.delete();
    rows.push_back(mk(16'd8000, 0, 0, 0, 0));
    rows.push_back(mk(16'd8001, 0, 0, 0, 0));
    rows.push_back(mk(16'd14000, 0, 0, 0, 0));
    rows.push_back(mk(16'd20000, 0, 0, 0, 0));
    rows.push_back(mk(16'd20001, 0, 0, 0, 0));
    rows.push_back(mk(-16'd8001, 0, 0, 0, 0));
    rows.push_back(mk(-16'd14000, 0, 0, 0, 0));
    rows.push_back(mk(-16'd20001, 0, 0, 0, 0));
    rows.push_back(mk(16'h8000, 0, 0, 0, 0));
    rows.push_back(mk(16'h7FFF, 0, 0, 0, 0));
    foreach (rows[i]) send_speed(rows[i].cmd, map_speed(rows[i].cmd));
    rx_random = 1'b1;
    random_speeds(RAND_PER);

    // Hold the sender off until every expected result has come back.
    speed_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    random_speeds(20);
    drain();

    // Extremes: widest clamp, zero mid, largest and zero biases.
    set_all(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_speed(16'h8000, map_speed(16'h8000));
    send_speed(16'h7FFF, map_speed(16'h7FFF));
    random_speeds(RAND_PER);
    drain();

    // Mid at or above max leaves the blend bands empty; a zero clamp too.
    set_all(16'd1000, 16'd5000, 16'd16385, 16'd40000, 16'd16383, 16'd100);
    random_speeds(RAND_PER);
    drain();
    set_all(16'h0000, 16'h7FFF, 16'd50000, 16'd1, 16'd1, 16'd50000);
    random_speeds(40);
    drain();

    // Fully random register settings for the remainder.
    set_all(16'($urandom), 16'($urandom_range(0, 12000)), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom));
    random_speeds(RAND_PER);
    drain();

    if (errors == 0) begin
      $display("drive_speed_bias_mapper verification clean");
    end else begin
      $display("drive_speed_bias_mapper verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
